// File: hw/rtl/dcfg_pkg.sv
// dcfg_pkg: shared types, constants and the control store of the dash cluster
// frame generator. No dependencies.
package dcfg_pkg;

  localparam int RPM_W   = 14;
  localparam int TEMP_W  = 9;
  localparam int KPH_W   = 16;
  localparam int MS_W    = 32;
  localparam int ID_W    = 11;
  localparam int LEN_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int NBYTES  = 8;
  localparam int PC_W    = 4;

  localparam logic [BYTE_W-1:0] TEMP_OFFSET_RST = 8'd49;
  localparam logic [BYTE_W-1:0] ROLL_HI_RST     = 8'hF0;
  localparam logic [15:0]       ODO_RST         = 16'hF000;
  localparam logic [15:0]       ODO_LIMIT       = 16'hFFF0;
  localparam logic [15:0]       MPH_Q16         = 16'd40722;
  localparam logic [6:0]        DIV_BY          = 7'd50;
  localparam logic [6:0]        ODO_STEP        = 7'd100;
  // floor(x / 50) as ((x >> 1) * DIV_RECIP) >> DIV_SHIFT for any 32-bit x
  localparam logic [30:0]       DIV_RECIP       = 31'd1374389535;
  localparam int                DIV_SHIFT       = 35;

  localparam logic [ID_W-1:0] ID_T15    = 11'h130;
  localparam logic [ID_W-1:0] ID_EBRAKE = 11'h34F;
  localparam logic [ID_W-1:0] ID_RPM    = 11'h175;
  localparam logic [ID_W-1:0] ID_TEMP   = 11'h1D0;
  localparam logic [ID_W-1:0] ID_BELT   = 11'h0D7;
  localparam logic [ID_W-1:0] ID_BRAKE  = 11'h19E;
  localparam logic [ID_W-1:0] ID_ABS    = 11'h0C0;
  localparam logic [ID_W-1:0] ID_FUEL   = 11'h349;
  localparam logic [ID_W-1:0] ID_GEAR   = 11'h1D2;
  localparam logic [ID_W-1:0] ID_SPEED  = 11'h1A6;

  typedef enum logic [3:0] {
    FRM_NONE, FRM_T15, FRM_EBRAKE, FRM_RPM, FRM_TEMP, FRM_BELT,
    FRM_BRAKE, FRM_ABS, FRM_FUEL, FRM_GEAR, FRM_SPEED
  } frame_sel_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_DIV, OP_MUL_A, OP_MUL_B, OP_DIST
  } arith_op_t;

  typedef enum logic [1:0] {
    JMP_WAIT_IN, JMP_NEXT, JMP_EVEN_TO_START, JMP_TO_START
  } jump_t;

  typedef struct packed {
    frame_sel_t frame;
    arith_op_t  op;
    jump_t      jmp;
  } ctl_word_t;

  localparam logic [PC_W-1:0] START_PC = '0;

  function automatic ctl_word_t ctl_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    case (pc)
      4'd0:    w = '{FRM_NONE,   OP_NOP,   JMP_WAIT_IN};
      4'd1:    w = '{FRM_T15,    OP_DIV,   JMP_NEXT};
      4'd2:    w = '{FRM_EBRAKE, OP_NOP,   JMP_NEXT};
      4'd3:    w = '{FRM_RPM,    OP_NOP,   JMP_NEXT};
      4'd4:    w = '{FRM_TEMP,   OP_NOP,   JMP_EVEN_TO_START};
      4'd5:    w = '{FRM_BELT,   OP_NOP,   JMP_NEXT};
      4'd6:    w = '{FRM_BRAKE,  OP_NOP,   JMP_NEXT};
      4'd7:    w = '{FRM_ABS,    OP_NOP,   JMP_NEXT};
      4'd8:    w = '{FRM_FUEL,   OP_NOP,   JMP_NEXT};
      4'd9:    w = '{FRM_GEAR,   OP_MUL_A, JMP_NEXT};
      4'd10:   w = '{FRM_NONE,   OP_MUL_B, JMP_NEXT};
      4'd11:   w = '{FRM_NONE,   OP_DIST,  JMP_NEXT};
      4'd12:   w = '{FRM_SPEED,  OP_NOP,   JMP_TO_START};
      default: w = '{FRM_NONE,   OP_NOP,   JMP_TO_START};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/dcfg_if.sv
// dcfg channel interfaces: tick input, frame output and register write.
// Depends on dcfg_pkg for field widths.
interface dcfg_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [dcfg_pkg::RPM_W-1:0]      engine_rpm;
  logic signed [dcfg_pkg::TEMP_W-1:0]     coolant_temp;
  logic signed [dcfg_pkg::TEMP_W-1:0]     oil_temp;
  logic        [dcfg_pkg::KPH_W-1:0]      speed_kph_q8;
  logic        [dcfg_pkg::MS_W-1:0]       now_ms;
  modport source (output valid, engine_rpm, coolant_temp, oil_temp, speed_kph_q8,
                  now_ms, input ready);
  modport sink (input valid, engine_rpm, coolant_temp, oil_temp, speed_kph_q8,
                now_ms, output ready);
endinterface

interface dcfg_out_if;
  logic                          valid;
  logic                          ready;
  logic [dcfg_pkg::ID_W-1:0]     frame_id;
  logic [dcfg_pkg::LEN_W-1:0]    frame_length;
  logic [dcfg_pkg::BYTE_W-1:0]   data0;
  logic [dcfg_pkg::BYTE_W-1:0]   data1;
  logic [dcfg_pkg::BYTE_W-1:0]   data2;
  logic [dcfg_pkg::BYTE_W-1:0]   data3;
  logic [dcfg_pkg::BYTE_W-1:0]   data4;
  logic [dcfg_pkg::BYTE_W-1:0]   data5;
  logic [dcfg_pkg::BYTE_W-1:0]   data6;
  logic [dcfg_pkg::BYTE_W-1:0]   data7;
  logic                          last_frame;
  modport source (output valid, frame_id, frame_length, data0, data1, data2, data3,
                  data4, data5, data6, data7, last_frame, input ready);
  modport sink (input valid, frame_id, frame_length, data0, data1, data2, data3,
                data4, data5, data6, data7, last_frame, output ready);
endinterface

interface dcfg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dcfg_pkg::BYTE_W-1:0]   temp_offset;
  modport source (output valid, temp_offset, input ready);
  modport sink (input valid, temp_offset, output ready);
endinterface

// File: hw/rtl/dash_cluster_frame_generator_core.sv
// dash_cluster_frame_generator_core: microcoded frame sequencer for the cluster
// The first frame is registered once a tick is taken and the output is free.
// 4 frames per even tick, 10 per odd, set by the control store, one step per
// cycle unless the output stalls; ticks are taken only at the wait step. The
// divide by 50 is one reciprocal multiply step; distance: MUL_A, MUL_B, DIST.
// Reset: synchronous, active low; clears counters, sequencer and output valid.
module dash_cluster_frame_generator_core (
  input  logic       clk,
  input  logic       rst_n,
  dcfg_in_if.sink    in_if,
  dcfg_out_if.source out_if,
  dcfg_cfg_if.sink   cfg_if
);
  import dcfg_pkg::*;

  // sequencer
  logic [PC_W-1:0]   pc_r, pc_nxt;
  ctl_word_t         ctl;
  logic              emit, advance, accept, out_free, last;

  // configuration and tick state
  logic [BYTE_W-1:0] temp_offset_r, temp_offset_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [BYTE_W-1:0] rpm_roll_r, rpm_roll_nxt;
  logic [3:0]        temp_roll_r, temp_roll_nxt;
  logic [BYTE_W-1:0] belt_roll_r, belt_roll_nxt;
  logic [BYTE_W-1:0] brake_a_r, brake_a_nxt;
  logic [BYTE_W-1:0] brake_b_r, brake_b_nxt;
  logic [BYTE_W-1:0] abs_roll_r, abs_roll_nxt;
  logic [3:0]        gear_roll_r, gear_roll_nxt;
  logic [BYTE_W-1:0] dist_r, dist_nxt;
  logic [MS_W-1:0]   stamp_r, stamp_nxt;
  logic [15:0]       odo_r, odo_nxt;

  // latched tick fields and arithmetic datapath
  logic [RPM_W-1:0]  rpm_r, rpm_nxt;
  logic [BYTE_W-1:0] clt_r, clt_nxt;
  logic [BYTE_W-1:0] oil_r, oil_nxt;
  logic [KPH_W-1:0]  kph_r, kph_nxt;
  logic [31:0]       k_r;
  logic [MS_W-1:0]   dvd_r, dvd_nxt;
  logic [32:0]       acc_r, acc_nxt;
  logic [15:0]       odo_inc_r, odo_inc_nxt;
  logic [61:0]       div_prod;
  logic [32:0]       mul_lo;
  logic [16:0]       mul_hi;
  logic [15:0]       mul_odo;
  logic [15:0]       odo_sum;
  logic [15:0]       rpm4;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [BYTE_W-1:0] out_data_r [NBYTES];
  logic [BYTE_W-1:0] out_data_nxt [NBYTES];
  logic              out_last_r, out_last_nxt;

  // frame builder
  logic [ID_W-1:0]   frm_id;
  logic [LEN_W-1:0]  frm_len;
  logic [BYTE_W-1:0] frm_data [NBYTES];

  assign ctl      = ctl_rom(pc_r);
  assign emit     = (ctl.frame != FRM_NONE);
  assign out_free = !out_valid_r || out_if.ready;
  assign accept   = in_if.valid && in_if.ready;
  assign advance  = (ctl.jmp == JMP_WAIT_IN) ? in_if.valid : (!emit || out_free);
  assign last     = (ctl.jmp == JMP_TO_START) ||
                    ((ctl.jmp == JMP_EVEN_TO_START) && !tick_r[0]);

  assign in_if.ready  = (ctl.jmp == JMP_WAIT_IN);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid        = out_valid_r;
  assign out_if.frame_id     = out_id_r;
  assign out_if.frame_length = out_len_r;
  assign out_if.data0        = out_data_r[0];
  assign out_if.data1        = out_data_r[1];
  assign out_if.data2        = out_data_r[2];
  assign out_if.data3        = out_data_r[3];
  assign out_if.data4        = out_data_r[4];
  assign out_if.data5        = out_data_r[5];
  assign out_if.data6        = out_data_r[6];
  assign out_if.data7        = out_data_r[7];
  assign out_if.last_frame   = out_last_r;

  assign rpm4     = {rpm_r, 2'b00};
  assign div_prod = 62'(dvd_r[31:1]) * 62'(DIV_RECIP);
  assign mul_lo   = 33'(dvd_r[15:0]) * 33'(k_r);
  assign mul_hi   = 17'(dvd_r[26:16]) * k_r[16:0];
  assign mul_odo  = dvd_r[15:0] * 16'(ODO_STEP);
  assign odo_sum  = odo_r + odo_inc_r;

  // frame contents and rolling counters
  always_comb begin
    frm_id        = '0;
    frm_len       = '0;
    frm_data      = '{default: '0};
    rpm_roll_nxt  = rpm_roll_r;
    temp_roll_nxt = temp_roll_r;
    belt_roll_nxt = belt_roll_r;
    brake_a_nxt   = brake_a_r;
    brake_b_nxt   = brake_b_r;
    abs_roll_nxt  = abs_roll_r;
    gear_roll_nxt = gear_roll_r;
    case (ctl.frame)
      FRM_T15: begin
        frm_id   = ID_T15;
        frm_len  = 4'd5;
        frm_data[0] = 8'h45; frm_data[1] = 8'h41; frm_data[2] = 8'h61;
        frm_data[3] = 8'h8F; frm_data[4] = 8'hFC;
      end
      FRM_EBRAKE: begin
        frm_id   = ID_EBRAKE;
        frm_len  = 4'd2;
        frm_data[0] = 8'hFD; frm_data[1] = 8'hFF;
      end
      FRM_RPM: begin
        rpm_roll_nxt = (rpm_roll_r == 8'hFE) ? ROLL_HI_RST : 8'(rpm_roll_r + 8'd1);
        if (rpm_roll_r == 8'hFF) begin
          rpm_roll_nxt = 8'h00;
        end
        frm_id   = ID_RPM;
        frm_len  = 4'd3;
        frm_data[0] = rpm_roll_nxt;
        frm_data[1] = rpm4[7:0];
        frm_data[2] = rpm4[15:8];
      end
      FRM_TEMP: begin
        temp_roll_nxt = (temp_roll_r >= 4'hE) ? 4'h0 : 4'(temp_roll_r + 4'd1);
        frm_id   = ID_TEMP;
        frm_len  = 4'd8;
        frm_data[0] = 8'(clt_r + temp_offset_r);
        frm_data[1] = 8'(oil_r + temp_offset_r);
        frm_data[2] = {4'h0, temp_roll_nxt};
        frm_data[3] = 8'hC8; frm_data[4] = 8'hA7; frm_data[5] = 8'hD3;
        frm_data[6] = 8'h0D; frm_data[7] = 8'hA8;
      end
      FRM_BELT: begin
        belt_roll_nxt = (belt_roll_r >= 8'hFE) ? 8'h00 : 8'(belt_roll_r + 8'd1);
        frm_id   = ID_BELT;
        frm_len  = 4'd2;
        frm_data[0] = belt_roll_nxt; frm_data[1] = 8'hFF;
      end
      FRM_BRAKE: begin
        brake_a_nxt = 8'(brake_a_r + 8'd16);
        brake_b_nxt = 8'(brake_b_r + 8'd16);
        if (brake_a_nxt > 8'hEF) begin
          brake_a_nxt = 8'h0F;
        end
        if (brake_b_nxt > 8'hF0) begin
          brake_b_nxt = 8'hA0;
        end
        frm_id   = ID_BRAKE;
        frm_len  = 4'd8;
        frm_data[0] = 8'h00; frm_data[1] = 8'hE0; frm_data[2] = brake_a_nxt;
        frm_data[3] = 8'hFC; frm_data[4] = 8'hFE; frm_data[5] = 8'h41;
        frm_data[6] = 8'h00; frm_data[7] = brake_b_nxt;
      end
      FRM_ABS: begin
        abs_roll_nxt = 8'(abs_roll_r + 8'd1);
        if (abs_roll_nxt > 8'hFE) begin
          abs_roll_nxt = ROLL_HI_RST;
        end
        frm_id   = ID_ABS;
        frm_len  = 4'd2;
        frm_data[0] = abs_roll_nxt; frm_data[1] = 8'hFF;
      end
      FRM_FUEL: begin
        frm_id   = ID_FUEL;
        frm_len  = 4'd5;
        frm_data[0] = 8'h76; frm_data[1] = 8'h0F; frm_data[2] = 8'hBE;
        frm_data[3] = 8'h1A; frm_data[4] = 8'h00;
      end
      FRM_GEAR: begin
        gear_roll_nxt = (gear_roll_r >= 4'hE) ? 4'h0 : 4'(gear_roll_r + 4'd1);
        frm_id   = ID_GEAR;
        frm_len  = 4'd6;
        frm_data[0] = 8'h78; frm_data[1] = 8'h0F; frm_data[2] = 8'hFF;
        frm_data[3] = {gear_roll_nxt, 4'hC};
        frm_data[4] = 8'hF1; frm_data[5] = 8'hFF;
      end
      FRM_SPEED: begin
        frm_id   = ID_SPEED;
        frm_len  = 4'd8;
        frm_data[0] = dist_r; frm_data[2] = dist_r; frm_data[4] = dist_r;
        frm_data[6] = odo_r[7:0];
        frm_data[7] = odo_r[15:8] | 8'hF0;
      end
      default: begin
        frm_id = '0;
      end
    endcase
  end

  // sequencer, datapath and output register next state
  always_comb begin
    pc_nxt          = pc_r;
    temp_offset_nxt = temp_offset_r;
    tick_nxt        = tick_r;
    dist_nxt        = dist_r;
    stamp_nxt       = stamp_r;
    odo_nxt         = odo_r;
    rpm_nxt         = rpm_r;
    clt_nxt         = clt_r;
    oil_nxt         = oil_r;
    kph_nxt         = kph_r;
    dvd_nxt         = dvd_r;
    acc_nxt         = acc_r;
    odo_inc_nxt     = odo_inc_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_id_nxt      = out_id_r;
    out_len_nxt     = out_len_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;

    if (cfg_if.valid) begin
      temp_offset_nxt = cfg_if.temp_offset;
    end

    if (accept) begin
      tick_nxt = (tick_r == 16'hFFFF) ? 16'd1 : 16'(tick_r + 16'd1);
      rpm_nxt  = in_if.engine_rpm;
      clt_nxt  = in_if.coolant_temp[7:0];
      oil_nxt  = in_if.oil_temp[7:0];
      kph_nxt  = in_if.speed_kph_q8;
      dvd_nxt  = in_if.now_ms - stamp_r;
      if (tick_nxt[0]) begin
        stamp_nxt = in_if.now_ms;
      end
    end

    if (advance) begin
      case (ctl.jmp)
        JMP_WAIT_IN:       pc_nxt = PC_W'(pc_r + 1'b1);
        JMP_NEXT:          pc_nxt = PC_W'(pc_r + 1'b1);
        JMP_EVEN_TO_START: pc_nxt = tick_r[0] ? PC_W'(pc_r + 1'b1) : START_PC;
        JMP_TO_START:      pc_nxt = START_PC;
        default:           pc_nxt = START_PC;
      endcase

      case (ctl.op)
        OP_DIV: begin
          dvd_nxt = 32'(div_prod >> DIV_SHIFT);
        end
        OP_MUL_A: begin
          acc_nxt     = mul_lo;
          odo_inc_nxt = mul_odo;
        end
        OP_MUL_B: begin
          acc_nxt = 33'(acc_r + {mul_hi, 16'h0000});
          odo_nxt = (odo_sum >= ODO_LIMIT) ? ODO_RST : odo_sum;
        end
        OP_DIST: begin
          dist_nxt = 8'(dist_r + acc_r[32:25]);
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase

      if (emit) begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = frm_id;
        out_len_nxt   = frm_len;
        out_data_nxt  = frm_data;
        out_last_nxt  = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= START_PC;
      temp_offset_r <= TEMP_OFFSET_RST;
      tick_r        <= '0;
      rpm_roll_r    <= '0;
      temp_roll_r   <= '0;
      belt_roll_r   <= '0;
      brake_a_r     <= ROLL_HI_RST;
      brake_b_r     <= ROLL_HI_RST;
      abs_roll_r    <= ROLL_HI_RST;
      gear_roll_r   <= '0;
      dist_r        <= '0;
      stamp_r       <= '0;
      odo_r         <= ODO_RST;
      out_valid_r   <= 1'b0;
    end else begin
      pc_r          <= pc_nxt;
      temp_offset_r <= temp_offset_nxt;
      tick_r        <= tick_nxt;
      if (advance) begin
        rpm_roll_r  <= rpm_roll_nxt;
        temp_roll_r <= temp_roll_nxt;
        belt_roll_r <= belt_roll_nxt;
        brake_a_r   <= brake_a_nxt;
        brake_b_r   <= brake_b_nxt;
        abs_roll_r  <= abs_roll_nxt;
        gear_roll_r <= gear_roll_nxt;
      end
      dist_r        <= dist_nxt;
      stamp_r       <= stamp_nxt;
      odo_r         <= odo_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    rpm_r      <= rpm_nxt;
    clt_r      <= clt_nxt;
    oil_r      <= oil_nxt;
    kph_r      <= kph_nxt;
    k_r        <= 32'(kph_r) * 32'(MPH_Q16);
    dvd_r      <= dvd_nxt;
    acc_r      <= acc_nxt;
    odo_inc_r  <= odo_inc_nxt;
    out_id_r   <= out_id_nxt;
    out_len_r  <= out_len_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: verif/dcfg_checker.sv
`timescale 1ns / 100ps
// dcfg_checker: watches the tick, frame and register channels of the cluster
// frame generator, predicts the frames of each tick and compares them in order.
// Depends on dcfg_pkg and the dcfg channel interfaces.
module dcfg_checker
  import dcfg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dcfg_in_if   in_mon,
  dcfg_out_if  out_mon,
  dcfg_cfg_if  cfg_mon,
  output int   fail_count,
  output int   frames_pending
);

  typedef logic [NBYTES-1:0][BYTE_W-1:0] frame_bytes_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    frame_bytes_t     data;
    logic             last;
  } cluster_frame_t;

  cluster_frame_t frame_q[$];
  int             frames_checked;

  logic [BYTE_W-1:0] temp_offset;
  logic [15:0]       tick_count;
  logic [7:0]        rpm_roll;
  logic [3:0]        temp_roll;
  logic [7:0]        belt_roll;
  logic [7:0]        brake_roll_a;
  logic [7:0]        brake_roll_b;
  logic [7:0]        abs_roll;
  logic [3:0]        gear_roll;
  logic [7:0]        distance_byte;
  logic [MS_W-1:0]   speed_stamp;
  logic [15:0]       odometer;

  initial begin
    fail_count = 0;
    frames_checked = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (fail_count < 100) begin
      $display("%0t: frame %0d %s: expected %0h, got %0h", $time, frames_checked,
               what, want, got);
    end
    fail_count++;
  endtask

  function automatic frame_bytes_t pack_bytes(
      input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
      input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
      input logic [7:0] b6, input logic [7:0] b7);
    return {b7, b6, b5, b4, b3, b2, b1, b0};
  endfunction

  // bytes past the frame length read as zero
  task automatic push_frame(input logic [ID_W-1:0] id, input int len,
                            input frame_bytes_t b, input logic last);
    cluster_frame_t f;
    f.id   = id;
    f.len  = LEN_W'(len);
    f.data = '0;
    for (int i = 0; i < len; i++) f.data[i] = b[i];
    f.last = last;
    frame_q.push_back(f);
  endtask

  task automatic predict_tick(input logic [RPM_W-1:0] rpm, input logic [TEMP_W-1:0] clt,
                              input logic [TEMP_W-1:0] oil, input logic [KPH_W-1:0] kph,
                              input logic [MS_W-1:0] now);
    logic [15:0]     rpm4;
    logic            odd;
    logic [MS_W-1:0] elapsed;
    logic [63:0]     intervals;
    logic [63:0]     dist_step;
    logic [63:0]     odo_sum;
    logic [7:0]      clt_byte;
    logic [7:0]      oil_byte;

    if (tick_count == 16'hFFFF) tick_count = '0;
    tick_count = tick_count + 16'd1;
    odd = tick_count[0];

    push_frame(ID_T15, 5, pack_bytes(8'h45, 8'h41, 8'h61, 8'h8F, 8'hFC, 8'h00, 8'h00,
                                     8'h00), 1'b0);
    push_frame(ID_EBRAKE, 2, pack_bytes(8'hFD, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        8'h00), 1'b0);

    rpm_roll = rpm_roll + 8'd1;
    if (rpm_roll > 8'hFE) rpm_roll = ROLL_HI_RST;
    rpm4 = {rpm, 2'b00};
    push_frame(ID_RPM, 3, pack_bytes(rpm_roll, rpm4[7:0], rpm4[15:8], 8'h00, 8'h00, 8'h00,
                                     8'h00, 8'h00), 1'b0);

    temp_roll = temp_roll + 4'd1;
    if (temp_roll >= 4'hF) temp_roll = '0;
    clt_byte = clt[7:0] + temp_offset;
    oil_byte = oil[7:0] + temp_offset;
    push_frame(ID_TEMP, 8, pack_bytes(clt_byte, oil_byte, {4'h0, temp_roll}, 8'hC8, 8'hA7,
                                      8'hD3, 8'h0D, 8'hA8), !odd);

    if (odd) begin
      belt_roll = belt_roll + 8'd1;
      if (belt_roll > 8'hFE) belt_roll = '0;
      push_frame(ID_BELT, 2, pack_bytes(belt_roll, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        8'h00), 1'b0);

      brake_roll_a = brake_roll_a + 8'd16;
      brake_roll_b = brake_roll_b + 8'd16;
      if (brake_roll_a > 8'hEF) brake_roll_a = 8'h0F;
      if (brake_roll_b > 8'hF0) brake_roll_b = 8'hA0;
      push_frame(ID_BRAKE, 8, pack_bytes(8'h00, 8'hE0, brake_roll_a, 8'hFC, 8'hFE, 8'h41,
                                         8'h00, brake_roll_b), 1'b0);

      abs_roll = abs_roll + 8'd1;
      if (abs_roll > 8'hFE) abs_roll = ROLL_HI_RST;
      push_frame(ID_ABS, 2, pack_bytes(abs_roll, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                       8'h00), 1'b0);

      push_frame(ID_FUEL, 5, pack_bytes(8'h76, 8'h0F, 8'hBE, 8'h1A, 8'h00, 8'h00, 8'h00,
                                        8'h00), 1'b0);

      gear_roll = gear_roll + 4'd1;
      if (gear_roll >= 4'hF) gear_roll = '0;
      push_frame(ID_GEAR, 6, pack_bytes(8'h78, 8'h0F, 8'hFF, {gear_roll, 4'hC}, 8'hF1, 8'hFF,
                                        8'h00, 8'h00), 1'b0);

      // distance from whole 50 ms intervals since the last speed frame
      elapsed   = now - speed_stamp;
      intervals = 64'(elapsed / MS_W'(DIV_BY));
      dist_step = (intervals * 64'(kph) * 64'(MPH_Q16)) >> 25;
      distance_byte = distance_byte + dist_step[7:0];
      odo_sum  = 64'(odometer) + intervals * 64'(ODO_STEP);
      odometer = odo_sum[15:0];
      if (odometer >= ODO_LIMIT) odometer = ODO_RST;
      speed_stamp = now;
      push_frame(ID_SPEED, 8, pack_bytes(distance_byte, 8'h00, distance_byte, 8'h00,
                                         distance_byte, 8'h00, odometer[7:0],
                                         odometer[15:8] | 8'hF0), 1'b1);
    end
  endtask

  task automatic check_frame();
    cluster_frame_t got;
    cluster_frame_t want;

    got.id   = out_mon.frame_id;
    got.len  = out_mon.frame_length;
    got.data = {out_mon.data7, out_mon.data6, out_mon.data5, out_mon.data4,
                out_mon.data3, out_mon.data2, out_mon.data1, out_mon.data0};
    got.last = out_mon.last_frame;
    if (frame_q.size() == 0) begin
      report_mismatch("frame with nothing pending, frame_id", '0, 64'(got.id));
    end else begin
      want = frame_q.pop_front();
      if (got.id !== want.id) report_mismatch("frame_id", 64'(want.id), 64'(got.id));
      if (got.len !== want.len) begin
        report_mismatch("frame_length", 64'(want.len), 64'(got.len));
      end
      for (int i = 0; i < NBYTES; i++) begin
        if (got.data[i] !== want.data[i]) begin
          report_mismatch($sformatf("data%0d", i), 64'(want.data[i]), 64'(got.data[i]));
        end
      end
      if (got.last !== want.last) begin
        report_mismatch("last_frame", 64'(want.last), 64'(got.last));
      end
    end
    frames_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      temp_offset   = TEMP_OFFSET_RST;
      tick_count    = '0;
      rpm_roll      = '0;
      temp_roll     = '0;
      belt_roll     = '0;
      brake_roll_a  = ROLL_HI_RST;
      brake_roll_b  = ROLL_HI_RST;
      abs_roll      = ROLL_HI_RST;
      gear_roll     = '0;
      distance_byte = '0;
      speed_stamp   = '0;
      odometer      = ODO_RST;
      frame_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) temp_offset = cfg_mon.temp_offset;
      if (out_mon.valid && out_mon.ready) check_frame();
      if (in_mon.valid && in_mon.ready) begin
        predict_tick(in_mon.engine_rpm, in_mon.coolant_temp, in_mon.oil_temp,
                     in_mon.speed_kph_q8, in_mon.now_ms);
      end
    end
    frames_pending <= frame_q.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// testbench: drives ticks and temperature offset writes into the cluster frame
// generator, with random idling on both sides; dcfg_checker does the checking.
// Depends on dcfg_pkg, the dcfg channel interfaces, the core and dcfg_checker.
module testbench;
  import dcfg_pkg::*;

  localparam int QUIET_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [RPM_W-1:0]  rpm;
    logic [TEMP_W-1:0] clt;
    logic [TEMP_W-1:0] oil;
    logic [KPH_W-1:0]  kph;
    logic [MS_W-1:0]   now;
  } tick_t;

  logic clk;
  logic rst_n;

  dcfg_in_if  in_if();
  dcfg_out_if out_if();
  dcfg_cfg_if cfg_if();

  int              fail_count;
  int              frames_pending;
  bit              tx_idle_en   = 1'b1;
  bit              rx_idle_en   = 1'b1;
  int              rx_hold_left = 0;
  int              quiet_cycles = 0;
  logic [MS_W-1:0] last_now     = '0;

  dash_cluster_frame_generator_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  dcfg_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .cfg_mon        (cfg_if),
    .fail_count     (fail_count),
    .frames_pending (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // frame receiver: random idling plus a long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_if.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_if.ready <= !(rx_idle_en && $urandom_range(99) < 33);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** dash_cluster_frame_generator_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_t make_tick(input int rpm, input int clt, input int oil,
                                      input int kph, input logic [MS_W-1:0] now);
    tick_t t;
    t.rpm = RPM_W'(rpm);
    t.clt = TEMP_W'(clt);
    t.oil = TEMP_W'(oil);
    t.kph = KPH_W'(kph);
    t.now = now;
    return t;
  endfunction

  // mostly a steady clock advance, sometimes a jump anywhere
  function automatic tick_t rand_tick();
    tick_t t;
    t.rpm = RPM_W'($urandom());
    t.clt = TEMP_W'($urandom());
    t.oil = TEMP_W'($urandom());
    t.kph = KPH_W'($urandom());
    if ($urandom_range(99) < 75) t.now = last_now + $urandom_range(3000);
    else t.now = $urandom();
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    while (tx_idle_en && $urandom_range(99) < 33) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.engine_rpm   <= t.rpm;
    in_if.coolant_temp <= t.clt;
    in_if.oil_temp     <= t.oil;
    in_if.speed_kph_q8 <= t.kph;
    in_if.now_ms       <= t.now;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    last_now = t.now;
  endtask

  task automatic drain_frames();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
  endtask

  task automatic write_offset(input logic [BYTE_W-1:0] value);
    cfg_if.valid       <= 1'b1;
    cfg_if.temp_offset <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.engine_rpm   <= '0;
    in_if.coolant_temp <= '0;
    in_if.oil_temp     <= '0;
    in_if.speed_kph_q8 <= '0;
    in_if.now_ms       <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.temp_offset <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset offset; first speed frame lands the odometer on its limit
    send_tick(make_tick(0, -128, 255, 0, 32'd657400));
    send_tick(make_tick(16383, 255, -128, 16'hFFFF, 32'd0));
    send_tick(make_tick(16383, -1, -256, 16'hFFFF, 32'hFFFF_FFFF));
    send_tick(make_tick(1, 0, 0, 16'h8000, 32'hFFFF_FFF0));
    // millisecond clock wraps between speed frames
    send_tick(make_tick(8191, 100, -40, 16'hFFFF, 32'd49));
    send_tick(make_tick(2, 1, 1, 1, 32'd60));
    send_tick(make_tick(100, 90, 110, 16'h0100, 32'd149));
    send_tick(make_tick(0, 0, 0, 0, 32'd149));
    send_tick(make_tick(5000, -20, 20, 16'h2000, 32'd149));
    for (int i = 0; i < 11; i++) send_tick(rand_tick());
    drain_frames();

    write_offset(8'hFF);
    for (int i = 0; i < 40; i++) send_tick(rand_tick());
    drain_frames();

    write_offset(8'h00);
    for (int i = 0; i < 40; i++) begin
      if (i == 10) rx_hold_left = RX_HOLD_CYCLES;
      if (i == 25) drain_frames();
      send_tick(rand_tick());
    end
    drain_frames();

    write_offset(BYTE_W'($urandom_range(1, 254)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 60; i++) begin
      if (i == 30) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      send_tick(rand_tick());
    end
    drain_frames();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** dash_cluster_frame_generator_core: PASSED **");
    end else begin
      $display("** dash_cluster_frame_generator_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: dash_cluster_frame_generator_core.f
hw/rtl/dcfg_pkg.sv
hw/rtl/dcfg_if.sv
hw/rtl/dash_cluster_frame_generator_core.sv
verif/dcfg_checker.sv
verif/testbench.sv
